// ===== rtl/vtp_pkg.sv =====
// Shared types, constants and helpers for the vertex transform and projection block.
package vtp_pkg;

  typedef struct packed {
    logic [1:0]          axis;
    logic signed [15:0]  cos_a;
    logic signed [15:0]  sin_a;
    logic [30:0]         scale;
    logic signed [31:0]  tx;
    logic signed [31:0]  ty;
    logic signed [31:0]  tz;
    logic [30:0]         proj;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_AXIS  = 3'd0,
    REG_COS   = 3'd1,
    REG_SIN   = 3'd2,
    REG_SCALE = 3'd3,
    REG_TX    = 3'd4,
    REG_TY    = 3'd5,
    REG_TZ    = 3'd6,
    REG_PROJ  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

  // Denominator width, numerator width, divisor magnitude width, quotient bits
  localparam int DW = 48;
  localparam int NW = 64;
  localparam int MW = 48;
  localparam int QB = 15;

  localparam int XF_LAT  = 6;
  localparam int DIV_LAT = QB + 2;
  localparam int PJ_LAT  = DIV_LAT + 6;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7FFFFFFF;
    else if (v < S32_MIN) return 32'sh80000000;
    else return 32'(v);
  endfunction

endpackage

// ===== rtl/vtp_div.sv =====
// Pipelined restoring divider giving a quotient saturated to 16 bit signed.
module vtp_div
  import vtp_pkg::*;
(
  input  logic                clk,
  input  logic [NW-2:0]       num,
  input  logic [MW-1:0]       den,
  input  logic                neg,
  output logic signed [15:0]  quot
);

  logic [NW-2:0] rem_r [0:QB];
  logic [MW-1:0] den_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic          neg_r [0:QB];
  logic          ovf_r [0:QB];
  logic signed [15:0] quot_r;
  logic [16:0]   qmag;

  // quotient of 2^15 or more saturates either way
  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    neg_r[0] <= neg;
    q_r[0]   <= '0;
    ovf_r[0] <= (num >= ((NW-1)'(den) << QB));
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int B = QB - k;
    logic [NW-2:0] trial;
    logic          take;
    assign trial = (NW-1)'(den_r[k-1]) << B;
    assign take  = !ovf_r[k-1] && (rem_r[k-1] >= trial);
    always_ff @(posedge clk) begin
      rem_r[k] <= take ? (rem_r[k-1] - trial) : rem_r[k-1];
      q_r[k]   <= take ? (q_r[k-1] | (QB'(1) << B)) : q_r[k-1];
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign qmag = ovf_r[QB] ? 17'h08000 : {2'b00, q_r[QB]};

  always_ff @(posedge clk) begin
    if (neg_r[QB]) quot_r <= 16'(-qmag);
    else if (ovf_r[QB]) quot_r <= 16'sh7FFF;
    else quot_r <= 16'(qmag);
  end

  assign quot = quot_r;

endmodule

// ===== rtl/vtp_xform.sv =====
// Scale, rotate and translate pipeline for one vertex per clock.
module vtp_xform
  import vtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  output logic signed [31:0] out_px,
  output logic signed [31:0] out_py,
  output logic signed [31:0] out_pz
);

  logic [XF_LAT-1:0]  vld_r;
  logic signed [63:0] prod_r [0:2];
  logic signed [31:0] v_r    [0:2];
  logic signed [16:0] ca_r   [0:2];
  logic signed [16:0] cb_r   [0:2];
  logic signed [31:0] oa_r   [0:2];
  logic signed [31:0] ob_r   [0:2];
  logic signed [48:0] pa_r   [0:2];
  logic signed [48:0] pb_r   [0:2];
  logic signed [31:0] r_r    [0:2];
  logic signed [31:0] p_r    [0:2];

  logic signed [31:0] vin    [0:2];
  logic signed [31:0] tr     [0:2];
  logic signed [16:0] ca_nxt [0:2];
  logic signed [16:0] cb_nxt [0:2];
  logic signed [31:0] oa_nxt [0:2];
  logic signed [31:0] ob_nxt [0:2];
  logic signed [16:0] c, s, ns;

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign tr[0]  = cfg.tx;
  assign tr[1]  = cfg.ty;
  assign tr[2]  = cfg.tz;

  assign c  = 17'(cfg.cos_a);
  assign s  = 17'(cfg.sin_a);
  assign ns = -s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca_nxt[i] = ONE_Q14;
      oa_nxt[i] = v_r[i];
      cb_nxt[i] = '0;
      ob_nxt[i] = v_r[i];
    end
    unique case (cfg.axis)
      AXIS_X: begin
        ca_nxt[1] = c;  oa_nxt[1] = v_r[1]; cb_nxt[1] = s; ob_nxt[1] = v_r[2];
        ca_nxt[2] = ns; oa_nxt[2] = v_r[1]; cb_nxt[2] = c; ob_nxt[2] = v_r[2];
      end
      AXIS_Y: begin
        ca_nxt[0] = c;  oa_nxt[0] = v_r[0]; cb_nxt[0] = ns; ob_nxt[0] = v_r[2];
        ca_nxt[2] = s;  oa_nxt[2] = v_r[0]; cb_nxt[2] = c;  ob_nxt[2] = v_r[2];
      end
      AXIS_Z: begin
        ca_nxt[0] = c;  oa_nxt[0] = v_r[0]; cb_nxt[0] = s; ob_nxt[0] = v_r[1];
        ca_nxt[1] = ns; oa_nxt[1] = v_r[0]; cb_nxt[1] = c; ob_nxt[1] = v_r[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[XF_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= 64'(vin[i]) * 64'($signed({1'b0, cfg.scale}));
      v_r[i]    <= sat32(prod_r[i] >>> 16);
      ca_r[i]   <= ca_nxt[i];
      cb_r[i]   <= cb_nxt[i];
      oa_r[i]   <= oa_nxt[i];
      ob_r[i]   <= ob_nxt[i];
      pa_r[i]   <= 49'(ca_r[i]) * 49'(oa_r[i]);
      pb_r[i]   <= 49'(cb_r[i]) * 49'(ob_r[i]);
      r_r[i]    <= sat32((64'(pa_r[i]) + 64'(pb_r[i])) >>> 14);
      p_r[i]    <= sat32(64'(r_r[i]) + 64'(tr[i]));
    end
  end

  assign out_valid = vld_r[XF_LAT-1];
  assign out_px    = p_r[0];
  assign out_py    = p_r[1];
  assign out_pz    = p_r[2];

endmodule

// ===== rtl/vtp_project.sv =====
// Perspective divide and screen mapping pipeline.
module vtp_project
  import vtp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [30:0]        proj,
  input  logic               in_valid,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [31:0] in_pz,
  output logic               out_valid,
  output logic signed [15:0] out_sx,
  output logic signed [15:0] out_sy,
  output logic signed [31:0] out_pz,
  output logic               out_fault
);

  localparam logic signed [15:0] W_S = 16'(SCREEN_WIDTH);
  localparam logic signed [15:0] H_S = 16'(SCREEN_HEIGHT);

  typedef struct packed {
    logic               fault;
    logic               px_neg;
    logic               py_pos;
    logic signed [31:0] pz;
  } side_t;

  logic [4:0]         vp_r;
  logic [DIV_LAT-1:0] dv_r;
  side_t              sd_r [0:DIV_LAT-1];

  logic signed [63:0]   dprod_r;
  logic signed [31:0]   px1_r, py1_r, pz1_r;
  logic signed [DW-1:0] d_r;
  logic signed [31:0]   px2_r, py2_r, pz2_r;
  logic signed [DW:0]   sumx_r;
  logic signed [NW-1:0] hd_r, pw_r;
  logic [MW-1:0]        d2_r, d2b_r, d2c_r;
  logic                 dneg_r, dnegb_r;
  side_t                s3_r, s4_r, s5_r;
  logic signed [NW-1:0] nx_r, ny_r;
  logic [NW-2:0]        nxm_r, nym_r;
  logic                 negx_r, negy_r;

  logic [DW-2:0]        dmag;
  logic signed [15:0]   qx, qy;
  logic                 out_vld_r;
  logic signed [15:0]   sx_r, sy_r;
  logic signed [31:0]   pzo_r;
  logic                 fault_r;

  assign dmag = d_r[DW-1] ? (DW-1)'(-d_r) : (DW-1)'(d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r      <= '0;
      dv_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vp_r      <= {vp_r[3:0], in_valid};
      dv_r      <= {dv_r[DIV_LAT-2:0], vp_r[4]};
      out_vld_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    dprod_r <= 64'(in_pz) * 64'($signed({1'b0, proj}));
    px1_r   <= in_px;
    py1_r   <= in_py;
    pz1_r   <= in_pz;

    d_r   <= DW'(49'sd65536 - 49'(dprod_r >>> 16));
    px2_r <= px1_r;
    py2_r <= py1_r;
    pz2_r <= pz1_r;

    sumx_r <= (DW+1)'(d_r) + (DW+1)'(px2_r);
    hd_r   <= NW'(d_r) * NW'(H_S);
    pw_r   <= NW'(py2_r) * NW'(W_S);
    d2_r   <= {dmag, 1'b0};
    dneg_r <= d_r[DW-1];
    s3_r   <= '{fault: (d_r == '0), px_neg: px2_r[31], py_pos: (py2_r > 32'sd0), pz: pz2_r};

    nx_r    <= NW'(sumx_r) * NW'(W_S);
    ny_r    <= hd_r - pw_r;
    d2b_r   <= d2_r;
    dnegb_r <= dneg_r;
    s4_r    <= s3_r;

    nxm_r  <= nx_r[NW-1] ? (NW-1)'(-nx_r) : (NW-1)'(nx_r);
    nym_r  <= ny_r[NW-1] ? (NW-1)'(-ny_r) : (NW-1)'(ny_r);
    negx_r <= nx_r[NW-1] ^ dnegb_r;
    negy_r <= ny_r[NW-1] ^ dnegb_r;
    d2c_r  <= d2b_r;
    s5_r   <= s4_r;

    sd_r[0] <= s5_r;
    for (int i = 1; i < DIV_LAT; i++) sd_r[i] <= sd_r[i-1];
  end

  vtp_div u_div_x (
    .clk  (clk),
    .num  (nxm_r),
    .den  (d2c_r),
    .neg  (negx_r),
    .quot (qx)
  );

  vtp_div u_div_y (
    .clk  (clk),
    .num  (nym_r),
    .den  (d2c_r),
    .neg  (negy_r),
    .quot (qy)
  );

  always_ff @(posedge clk) begin
    if (sd_r[DIV_LAT-1].fault) begin
      sx_r <= sd_r[DIV_LAT-1].px_neg ? 16'sh8000 : 16'sh7FFF;
      sy_r <= sd_r[DIV_LAT-1].py_pos ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sx_r <= qx;
      sy_r <= qy;
    end
    pzo_r   <= sd_r[DIV_LAT-1].pz;
    fault_r <= sd_r[DIV_LAT-1].fault;
  end

  assign out_valid = out_vld_r;
  assign out_sx    = sx_r;
  assign out_sy    = sy_r;
  assign out_pz    = pzo_r;
  assign out_fault = fault_r;

endmodule

// ===== rtl/vertex_transform_project.sv =====
// Vertex transform and perspective projection top level with configuration registers.
// One vertex can be started on every clock; busy is only high during reset. Each word
// passes through scale, rotate and translate, then the denominator, the numerators and
// two 17-stage restoring dividers, and comes out marked by a single-cycle out_strobe;
// results are not held and cannot be stalled. Configuration writes are always ready
// and should be made only while no vertex is in flight.
module vertex_transform_project
  import vtp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic signed [31:0] in_vertex_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_strobe,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic signed [31:0] out_view_depth,
  output logic               out_in_front,
  output logic               out_divide_fault
);

  localparam int TOT_LAT = XF_LAT + PJ_LAT;

  cfg_t               cfg_r;
  logic               busy_r;
  logic               accept;
  logic               xf_valid;
  logic signed [31:0] px, py, pz;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cfg_r  <= '{axis: AXIS_Y, cos_a: 16'sd16384, sin_a: 16'sd0, scale: 31'd65536,
                  tx: 32'sd0, ty: 32'sd0, tz: -32'sd196608, proj: 31'd113512};
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_AXIS:  cfg_r.axis  <= cfg_data[1:0];
          REG_COS:   cfg_r.cos_a <= cfg_data[15:0];
          REG_SIN:   cfg_r.sin_a <= cfg_data[15:0];
          REG_SCALE: cfg_r.scale <= cfg_data[30:0];
          REG_TX:    cfg_r.tx    <= cfg_data;
          REG_TY:    cfg_r.ty    <= cfg_data;
          REG_TZ:    cfg_r.tz    <= cfg_data;
          REG_PROJ:  cfg_r.proj  <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
    end
  end

  vtp_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (accept),
    .in_x      (in_vertex_x),
    .in_y      (in_vertex_y),
    .in_z      (in_vertex_z),
    .out_valid (xf_valid),
    .out_px    (px),
    .out_py    (py),
    .out_pz    (pz)
  );

  vtp_project #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .proj      (cfg_r.proj),
    .in_valid  (xf_valid),
    .in_px     (px),
    .in_py     (py),
    .in_pz     (pz),
    .out_valid (out_strobe),
    .out_sx    (out_screen_x),
    .out_sy    (out_screen_y),
    .out_pz    (out_view_depth),
    .out_fault (out_divide_fault)
  );

  assign out_in_front = out_view_depth[31];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOT_LAT out_strobe)
    else $error("started word did not come out");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, TOT_LAT))
    else $error("word out without a start");

  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_divide_fault) |->
      ((out_screen_x == 16'sh7FFF) || (out_screen_x == 16'sh8000)) &&
      ((out_screen_y == 16'sh7FFF) || (out_screen_y == 16'sh8000)))
    else $error("fault word not saturated");

endmodule
